[src/can_frame_unpacker_core_defines.svh]
// Assertion macros shared by the CAN frame unpacker RTL.
// Needs clk and rst_n in scope at the point of use; no other dependencies.
`ifndef CAN_FRAME_UNPACKER_CORE_DEFINES_SVH
`define CAN_FRAME_UNPACKER_CORE_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define CFU_ASSERT_COMB(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define CFU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/cfu_pkg.sv]
// Types and constants for the CAN frame unpacker.
// No dependencies; used by the interfaces' users, the parser and the top level.
`timescale 1ns / 1ps

package cfu_pkg;

    localparam int unsigned MAX_DATA_LEN = 8;
    localparam int unsigned IDX_W        = $clog2(MAX_DATA_LEN);
    localparam int unsigned LEN_W        = 4;

    typedef enum logic [2:0] {
        PH_ID_HI   = 3'd0,
        PH_ID_LO   = 3'd1,
        PH_LEN     = 3'd2,
        PH_DATA    = 3'd3,
        PH_DISCARD = 3'd4
    } phase_t;

    typedef logic [MAX_DATA_LEN-1:0][7:0] data_bytes_t;

    typedef struct packed {
        logic [15:0]      id;
        logic [LEN_W-1:0] len;
        data_bytes_t      payload;
    } frame_t;

endpackage

[src/cfu_stream_if.sv]
// Valid/ready channel interfaces: byte stream in, CAN frame out.
// No dependencies.
`timescale 1ns / 1ps

interface cfu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface cfu_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] frame_id;
    logic [3:0]  frame_len;
    logic [7:0]  payload_0;
    logic [7:0]  payload_1;
    logic [7:0]  payload_2;
    logic [7:0]  payload_3;
    logic [7:0]  payload_4;
    logic [7:0]  payload_5;
    logic [7:0]  payload_6;
    logic [7:0]  payload_7;

    modport source (
        output valid, output frame_id, output frame_len,
        output payload_0, output payload_1, output payload_2, output payload_3,
        output payload_4, output payload_5, output payload_6, output payload_7,
        input  ready
    );
    modport sink (
        input  valid, input frame_id, input frame_len,
        input  payload_0, input payload_1, input payload_2, input payload_3,
        input  payload_4, input payload_5, input payload_6, input payload_7,
        output ready
    );
endinterface

[src/can_frame_unpacker_core.sv]
// CAN frame unpacker top level: parser plus a two-deep output register/skid.
// Depends on cfu_pkg, cfu_stream_if, cfu_parser and the defines header.
`timescale 1ns / 1ps
`include "can_frame_unpacker_core_defines.svh"

// Usage
//   in_ch  : one packet byte per transfer, last_byte set on the packet's final byte.
//   out_ch : one CAN frame per transfer (ID, length, eight payload bytes with the
//            bytes at or beyond the length reading zero).
//   Frames are laid out as ID high, ID low, length, then length data bytes. A
//   length above eight drops the rest of the packet; a frame cut short by the
//   end of the packet is dropped; the parser always restarts after last_byte.
// Output: the frame enters the output register, or the skid stage while that
//   is held, on the transfer of its final data byte (or length byte if zero).
// Throughput: one byte per cycle while the skid stage is empty; frames can leave
//   at one per cycle while out_ch.ready is high.
// Reset: parser back to expecting an ID high byte, data store cleared, output
//   register and skid stage empty.
// Stall: a held frame sits in the output register; one more frame fits in the
//   skid stage, and in_ch.ready drops only while the skid stage is occupied.
module can_frame_unpacker_core
    import cfu_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    cfu_in_if.sink    in_ch,
    cfu_out_if.source out_ch
);

    logic   in_fire;
    logic   emit;
    logic   push;
    logic   out_free;
    frame_t frame;

    logic   main_valid_reg, main_valid_next;
    logic   skid_valid_reg, skid_valid_next;
    frame_t main_reg, main_next;
    frame_t skid_reg, skid_next;

    // input stalls only once the skid stage holds a frame
    assign in_ch.ready = !skid_valid_reg;
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign push        = in_fire && emit;
    assign out_free    = !main_valid_reg || out_ch.ready;

    cfu_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (in_fire),
        .data_byte (in_ch.data_byte),
        .last_byte (in_ch.last_byte),
        .emit      (emit),
        .frame     (frame)
    );

    // output register with skid: the skid always drains into main first
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                main_valid_next = 1'b1;
                main_next       = skid_reg;
                skid_valid_next = push;
                skid_next       = frame;
            end
            else
            begin
                main_valid_next = push;
                main_next       = frame;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_next       = frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign out_ch.valid     = main_valid_reg;
    assign out_ch.frame_id  = main_reg.id;
    assign out_ch.frame_len = main_reg.len;
    assign out_ch.payload_0 = main_reg.payload[0];
    assign out_ch.payload_1 = main_reg.payload[1];
    assign out_ch.payload_2 = main_reg.payload[2];
    assign out_ch.payload_3 = main_reg.payload[3];
    assign out_ch.payload_4 = main_reg.payload[4];
    assign out_ch.payload_5 = main_reg.payload[5];
    assign out_ch.payload_6 = main_reg.payload[6];
    assign out_ch.payload_7 = main_reg.payload[7];

    `CFU_ASSERT_COMB(a_skid_behind_main, skid_valid_reg, main_valid_reg,
        "skid stage full while output register empty")
    `CFU_ASSERT_NEXT(a_skid_kept, skid_valid_reg && !out_ch.ready, skid_valid_reg,
        "skid frame lost during stall")
    `CFU_ASSERT_NEXT(a_stall_to_skid, main_valid_reg && !out_ch.ready && push,
        skid_valid_reg, "new frame not caught by skid stage during stall")

endmodule

[src/cfu_parser.sv]
// Byte-level frame parser: phase register, header/data hold registers.
// Depends on cfu_pkg and can_frame_unpacker_core_defines.svh.
`timescale 1ns / 1ps
`include "can_frame_unpacker_core_defines.svh"

module cfu_parser
    import cfu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       emit,
    output frame_t     frame
);

    phase_t           phase_reg, phase_next;
    logic [15:0]      id_reg, id_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] seen_reg, seen_next;
    data_bytes_t      store_reg, store_next;

    logic [LEN_W-1:0] seen_inc;
    logic             len_ok;

    assign seen_inc = seen_reg + LEN_W'(1);
    assign len_ok   = (data_byte <= 8'(MAX_DATA_LEN));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_ID_HI;
            id_reg    <= '0;
            len_reg   <= '0;
            seen_reg  <= '0;
            store_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            id_reg    <= id_next;
            len_reg   <= len_next;
            seen_reg  <= seen_next;
            store_reg <= store_next;
        end
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_ID_HI: phase_next = PH_ID_LO;
            PH_ID_LO: phase_next = PH_LEN;
            PH_LEN:
            begin
                if (!len_ok)
                    phase_next = PH_DISCARD;
                else if (data_byte == 8'd0)
                    phase_next = PH_ID_HI;
                else
                    phase_next = PH_DATA;
            end
            PH_DATA:
            begin
                if (seen_inc >= len_reg)
                    phase_next = PH_ID_HI;
            end
            default: phase_next = phase_reg;
        endcase
        if (last_byte)
            phase_next = PH_ID_HI;
    end

    // hold registers and frame build
    always_comb
    begin
        id_next    = id_reg;
        len_next   = len_reg;
        seen_next  = seen_reg;
        store_next = store_reg;
        emit       = 1'b0;
        case (phase_reg)
            PH_ID_HI: id_next = {data_byte, 8'h00};
            PH_ID_LO: id_next = {id_reg[15:8], data_byte};
            PH_LEN:
            begin
                if (len_ok)
                begin
                    len_next   = data_byte[LEN_W-1:0];
                    seen_next  = '0;
                    store_next = '0;
                    emit       = (data_byte == 8'd0);
                end
            end
            PH_DATA:
            begin
                if (seen_reg < LEN_W'(MAX_DATA_LEN))
                    store_next[seen_reg[IDX_W-1:0]] = data_byte;
                seen_next = seen_inc;
                emit      = (seen_inc >= len_reg);
            end
            default: emit = 1'b0;
        endcase

        frame.id  = id_next;
        frame.len = len_next;
        for (int k = 0; k < MAX_DATA_LEN; k++)
        begin
            frame.payload[k] = (LEN_W'(k) < len_next) ? store_next[k] : 8'h00;
        end
    end

    `CFU_ASSERT_COMB(a_emit_len_range, fire && emit, frame.len <= LEN_W'(MAX_DATA_LEN),
        "frame emitted with length above eight")
    `CFU_ASSERT_COMB(a_data_phase_count, phase_reg == PH_DATA,
        (len_reg != '0) && (seen_reg < len_reg), "data phase with count at or past length")
    `CFU_ASSERT_NEXT(a_last_resyncs, fire && last_byte, phase_reg == PH_ID_HI,
        "parser not back at header after last byte")

endmodule

[dv/can_frame_unpacker_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for can_frame_unpacker_core: a directed byte table, then random packets.
// Every frame is checked against an in-bench parser or the table; needs cfu_pkg, cfu_stream_if and the RTL.

module can_frame_unpacker_core_tb;
    import cfu_pkg::*;

    localparam int unsigned RANDOM_BYTES = 850;
    localparam int unsigned STALL_LIMIT  = 5000;
    localparam int unsigned DRAIN_CYCLES = 8;

    // Where a row's expectation comes from: the parser below, typed into the table, or none
    typedef enum logic [1:0] {EXP_PREDICT, EXP_FRAME, EXP_QUIET} exp_src_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
        exp_src_t   src;
        frame_t     frame;
    } feed_row_t;

    localparam frame_t ZERO_LEN_FRAME = '{id: 16'hFFFF, len: 4'd0, payload: '0};
    localparam frame_t FULL_FRAME     = '{id: 16'h0000, len: 4'd8,
                                          payload: 64'h0180_AA55_00FF_00FF};

    logic clk = 1'b0;
    logic rst_n;

    cfu_in_if  in_ch();
    cfu_out_if out_ch();

    can_frame_unpacker_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #5 clk = ~clk;

    feed_row_t   byte_feed[$];
    frame_t      frames_due[$];
    int unsigned dir_rows     = 0;
    int unsigned frames_seen  = 0;
    int unsigned err_cnt      = 0;
    int unsigned quiet_cycles = 0;
    int unsigned snd_idle_pct = 22;
    int unsigned rcv_idle_pct = 50;

    // Parser state, as after reset
    phase_t      ph_q    = PH_ID_HI;
    logic [15:0] id_q    = '0;
    logic [3:0]  len_q   = '0;
    logic [3:0]  seen_q  = '0;
    data_bytes_t store_q = '0;

    // Advance the parser by one byte; returns 1 with the frame when one completes
    function automatic bit unpack_byte(input logic [7:0] b, input logic last, output frame_t f);
        bit done;
        done = 1'b0;
        f    = '0;
        case (ph_q)
            PH_ID_HI:
            begin
                id_q = {b, 8'h00};
                ph_q = PH_ID_LO;
            end
            PH_ID_LO:
            begin
                id_q[7:0] = b;
                ph_q      = PH_LEN;
            end
            PH_LEN:
            begin
                if (b > MAX_DATA_LEN)
                begin
                    ph_q = PH_DISCARD;
                end
                else
                begin
                    len_q   = b[LEN_W-1:0];
                    seen_q  = '0;
                    store_q = '0;
                    if (b == 8'd0)
                    begin
                        done = 1'b1;
                        ph_q = PH_ID_HI;
                    end
                    else
                    begin
                        ph_q = PH_DATA;
                    end
                end
            end
            PH_DATA:
            begin
                if (seen_q < MAX_DATA_LEN)
                    store_q[seen_q[IDX_W-1:0]] = b;
                seen_q = seen_q + 4'd1;
                if (seen_q >= len_q)
                begin
                    done = 1'b1;
                    ph_q = PH_ID_HI;
                end
            end
            default: ;
        endcase
        // store is cleared at each length byte, so bytes past len are already zero
        if (done)
        begin
            f.id      = id_q;
            f.len     = len_q;
            f.payload = store_q;
        end
        if (last)
            ph_q = PH_ID_HI;
        return done;
    endfunction

    function automatic void add_row(input logic [7:0] d, input logic l, input exp_src_t s,
                                    input frame_t f);
        byte_feed.push_back('{data: d, last: l, src: s, frame: f});
    endfunction

    // Mostly well-formed packets of 1..4 frames; some cut short, some with an
    // over-long length, the rest plain noise
    task automatic build_random_feed();
        logic [7:0]  pkt[$];
        int unsigned r;
        int unsigned nfr;
        int unsigned len;
        int unsigned cut;
        while (byte_feed.size() < dir_rows + RANDOM_BYTES)
        begin
            pkt.delete();
            r = $urandom_range(99);
            if (r < 85)
            begin
                nfr = $urandom_range(1, 4);
                repeat (nfr)
                begin
                    len = $urandom_range(0, 8);
                    pkt.push_back(8'($urandom_range(255)));
                    pkt.push_back(8'($urandom_range(255)));
                    pkt.push_back(len[7:0]);
                    repeat (len) pkt.push_back(8'($urandom_range(255)));
                end
                if (r < 8 && pkt.size() > 1)
                begin
                    cut = $urandom_range(1, pkt.size() - 1);
                    while (pkt.size() > cut) void'(pkt.pop_back());
                end
                else if (r < 16)
                begin
                    pkt.push_back(8'($urandom_range(255)));
                    pkt.push_back(8'($urandom_range(255)));
                    pkt.push_back(8'($urandom_range(9, 255)));
                    repeat ($urandom_range(0, 5)) pkt.push_back(8'($urandom_range(255)));
                end
            end
            else
            begin
                repeat ($urandom_range(1, 12)) pkt.push_back(8'($urandom_range(255)));
            end
            foreach (pkt[k])
                add_row(pkt[k], k == pkt.size() - 1, EXP_PREDICT, '0);
        end
    endtask

    function automatic void cmp_field(input string fname, input logic [15:0] want,
                                      input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s expected %h, got %h", $time, fname, want, got);
            err_cnt++;
        end
    endfunction

    // Frame receiver with random back-pressure
    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // Frame checker
    always @(posedge clk)
    begin
        frame_t      want;
        data_bytes_t got_bytes;
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            frames_seen++;
            if (frames_due.size() == 0)
            begin
                $display("%0t ns: frame expected none, got id %h len %h", $time,
                         out_ch.frame_id, out_ch.frame_len);
                err_cnt++;
            end
            else
            begin
                want      = frames_due.pop_front();
                got_bytes = {out_ch.payload_7, out_ch.payload_6, out_ch.payload_5,
                             out_ch.payload_4, out_ch.payload_3, out_ch.payload_2,
                             out_ch.payload_1, out_ch.payload_0};
                cmp_field("frame_id", want.id, out_ch.frame_id);
                cmp_field("frame_len", 16'(want.len), 16'(out_ch.frame_len));
                for (int k = 0; k < MAX_DATA_LEN; k++)
                    cmp_field($sformatf("payload_%0d", k), 16'(want.payload[k]),
                              16'(got_bytes[k]));
            end
        end
    end

    // Watchdog: ends the run once no transfer has happened on either side for too long
    always @(posedge clk)
    begin
        if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
            (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t ns: watchdog, no transfer for %0d cycles, %0d frames outstanding",
                     $time, quiet_cycles, frames_due.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        int unsigned idx;
        int unsigned n;
        feed_row_t   cur;
        frame_t      f;
        bit          has;

        rst_n           <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= '0;
        in_ch.last_byte <= 1'b0;

        // zero-length frame straight after reset, ending the packet
        add_row(8'hFF, 1'b0, EXP_QUIET, '0);
        add_row(8'hFF, 1'b0, EXP_QUIET, '0);
        add_row(8'h00, 1'b1, EXP_FRAME, ZERO_LEN_FRAME);
        // full eight-byte frame, packet carries on
        add_row(8'h00, 1'b0, EXP_QUIET, '0);
        add_row(8'h00, 1'b0, EXP_QUIET, '0);
        add_row(8'h08, 1'b0, EXP_QUIET, '0);
        add_row(8'hFF, 1'b0, EXP_QUIET, '0);
        add_row(8'h00, 1'b0, EXP_QUIET, '0);
        add_row(8'hFF, 1'b0, EXP_QUIET, '0);
        add_row(8'h00, 1'b0, EXP_QUIET, '0);
        add_row(8'h55, 1'b0, EXP_QUIET, '0);
        add_row(8'hAA, 1'b0, EXP_QUIET, '0);
        add_row(8'h80, 1'b0, EXP_QUIET, '0);
        add_row(8'h01, 1'b0, EXP_FRAME, FULL_FRAME);
        // length of nine: rest of packet discarded
        add_row(8'h12, 1'b0, EXP_PREDICT, '0);
        add_row(8'h34, 1'b0, EXP_PREDICT, '0);
        add_row(8'h09, 1'b0, EXP_PREDICT, '0);
        add_row(8'h77, 1'b0, EXP_PREDICT, '0);
        add_row(8'hC3, 1'b1, EXP_PREDICT, '0);
        // largest length on the last byte
        add_row(8'hA5, 1'b0, EXP_PREDICT, '0);
        add_row(8'h5A, 1'b0, EXP_PREDICT, '0);
        add_row(8'hFF, 1'b1, EXP_PREDICT, '0);
        // packet ends inside the data, then inside the header
        add_row(8'h01, 1'b0, EXP_PREDICT, '0);
        add_row(8'h02, 1'b0, EXP_PREDICT, '0);
        add_row(8'h03, 1'b0, EXP_PREDICT, '0);
        add_row(8'hAB, 1'b1, EXP_PREDICT, '0);
        add_row(8'h7E, 1'b1, EXP_PREDICT, '0);
        dir_rows = byte_feed.size();
        build_random_feed();
        n = byte_feed.size();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        idx = 0;
        while (idx < n)
        begin
            @(posedge clk);
            if (in_ch.valid && in_ch.ready)
            begin
                cur = byte_feed[idx];
                has = unpack_byte(cur.data, cur.last, f);
                case (cur.src)
                    EXP_PREDICT: if (has) frames_due.push_back(f);
                    EXP_FRAME:   frames_due.push_back(cur.frame);
                    default: ;
                endcase
                idx++;
            end
            // pacing: receiver sparse first, then sender sparse, then flat out
            if (idx < n / 3)
            begin
                snd_idle_pct = 22;
                rcv_idle_pct = 50;
            end
            else if (idx < 2 * n / 3)
            begin
                snd_idle_pct = 50;
                rcv_idle_pct = 22;
            end
            else
            begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            if (in_ch.valid && !in_ch.ready)
            begin
                // byte still on offer, hold it
            end
            else if (idx < n && $urandom_range(99) >= snd_idle_pct)
            begin
                in_ch.valid     <= 1'b1;
                in_ch.data_byte <= byte_feed[idx].data;
                in_ch.last_byte <= byte_feed[idx].last;
            end
            else
            begin
                in_ch.valid <= 1'b0;
            end
        end

        while (frames_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d bytes (%0d from the directed table), three pacing phases",
                 n, dir_rows);
        $display("%0d frames compared, %0d field mismatches", frames_seen, err_cnt);
        if (err_cnt == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

[sim.f]
+incdir+src
src/cfu_pkg.sv
src/cfu_stream_if.sv
src/cfu_parser.sv
src/can_frame_unpacker_core.sv
dv/can_frame_unpacker_core_tb.sv
